// ===== design/lsc_pkg.sv =====
package lsc_pkg;

  localparam int SLOTS       = 8;
  localparam int SIDE        = 64;
  localparam int PLC         = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int SIDE_W      = $clog2(SIDE);
  localparam int H_W         = $clog2(PLC);
  localparam int DIM_W       = $clog2(SIDE) + 1;
  localparam int USR_W       = $clog2(PLC) + 1;
  localparam int CNT_W       = $clog2(PLC) + 1;
  localparam int STORE_DEPTH = SLOTS * SIDE * SIDE;
  localparam int PIX_W       = 33;
  localparam int DEN_W       = 17;
  localparam int MAG_W       = 49;
  localparam int NUM_W       = 50;
  localparam int DIV_LAST    = MAG_W - 1;

  typedef enum logic [3:0] {
    K_SIZE   = 4'd0,
    K_LOAD   = 4'd1,
    K_FREE   = 4'd2,
    K_PLACE  = 4'd3,
    K_RAISE  = 4'd4,
    K_LOWER  = 4'd5,
    K_TOP    = 4'd6,
    K_BOTTOM = 4'd7,
    K_REMOVE = 4'd8,
    K_MOTION = 4'd9,
    K_FRAME  = 4'd10,
    K_READ   = 4'd11
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BAD   = 2'd2,
    ST_INUSE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    R_CANVAS_W = 2'd0,
    R_CANVAS_H = 2'd1,
    R_BG_COLOR = 2'd2,
    R_RATE     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic [2:0]         sprite_slot;
    logic [3:0]         placement_handle;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic [31:0]        pixel_color;
    logic               pixel_opaque;
    logic [15:0]        frame_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  new_handle;
    logic [31:0] color_out;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic           capture;
    logic           exec;
    logic           reorder;
    logic           q_take;
    logic           frame;
    logic           fr_init;
    logic           fr_mul1;
    logic           fr_mul2;
    logic           fr_sum;
    logic           fr_div;
    logic           fr_wb;
    logic           load_out;
    logic [H_W-1:0] lidx;
    logic [H_W-1:0] fr_p;
    logic           fr_axis;
  } cmd_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic             h_ok;
    logic             in_canvas;
    logic             find_hit;
    logic             q_inside;
    logic             q_opaque;
    logic             p_valid;
    logic             out_free;
    logic [CNT_W-1:0] lcount;
  } stat_t;

endpackage

// ===== design/lsc_if.sv =====
interface lsc_in_if;
  logic              valid;
  logic              ready;
  lsc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsc_out_if;
  logic               valid;
  logic               ready;
  lsc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsc_cfg_if;
  logic               valid;
  logic               ready;
  lsc_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lsc_ram.sv =====
module lsc_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 32768,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/lsc_ctrl.sv =====
module lsc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lsc_pkg::stat_t stat_i,
  output lsc_pkg::cmd_t  cmd_o
);
  import lsc_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_EXEC  = 14'b00000000000010,
    S_FIND  = 14'b00000000000100,
    S_REORD = 14'b00000000001000,
    S_QLAY  = 14'b00000000010000,
    S_QWAIT = 14'b00000000100000,
    S_FINIT = 14'b00000001000000,
    S_FCHK  = 14'b00000010000000,
    S_FMUL1 = 14'b00000100000000,
    S_FMUL2 = 14'b00001000000000,
    S_FSUM  = 14'b00010000000000,
    S_FDIV  = 14'b00100000000000,
    S_FWB   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_e;

  localparam logic [H_W-1:0] P_LAST = H_W'(PLC - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [H_W-1:0]   p_q, p_d;
  logic             ax_q, ax_d;
  logic [5:0]       dc_q, dc_d;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    p_d         = p_q;
    ax_d        = ax_q;
    dc_d        = dc_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.lidx  = (state_q == S_QLAY) ? H_W'(k_q - CNT_W'(1)) : k_q[H_W-1:0];
    cmd_o.fr_p  = p_q;
    cmd_o.fr_axis = ax_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        case (kind_e'(stat_i.kind))
          K_RAISE, K_LOWER, K_TOP, K_BOTTOM, K_REMOVE: begin
            if (stat_i.h_ok) begin
              k_d = '0;
              state_d = S_FIND;
            end else begin
              state_d = S_DONE;
            end
          end
          K_FRAME: state_d = S_FINIT;
          K_READ: begin
            if (stat_i.in_canvas) begin
              k_d = stat_i.lcount;
              state_d = S_QLAY;
            end else begin
              state_d = S_DONE;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_FIND: begin
        if (stat_i.find_hit || k_q[H_W-1:0] == P_LAST) begin
          state_d = S_REORD;
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      S_REORD: begin
        cmd_o.reorder = 1'b1;
        state_d = S_DONE;
      end
      // walk layers top-down, one layer probe then, if the point is inside, one store read
      S_QLAY: begin
        if (k_q == '0) begin
          state_d = S_DONE;
        end else if (stat_i.q_inside) begin
          state_d = S_QWAIT;
        end else begin
          k_d = k_q - CNT_W'(1);
        end
      end
      S_QWAIT: begin
        if (stat_i.q_opaque) begin
          cmd_o.q_take = 1'b1;
          state_d = S_DONE;
        end else begin
          k_d = k_q - CNT_W'(1);
          state_d = S_QLAY;
        end
      end
      S_FINIT: begin
        cmd_o.fr_init = 1'b1;
        p_d = '0;
        ax_d = 1'b0;
        state_d = S_FCHK;
      end
      S_FCHK: begin
        cmd_o.frame = 1'b1;
        if (stat_i.p_valid) begin
          state_d = S_FMUL1;
        end else if (p_q == P_LAST) begin
          state_d = S_DONE;
        end else begin
          p_d = p_q + H_W'(1);
        end
      end
      S_FMUL1: begin
        cmd_o.frame = 1'b1;
        cmd_o.fr_mul1 = 1'b1;
        state_d = S_FMUL2;
      end
      S_FMUL2: begin
        cmd_o.frame = 1'b1;
        cmd_o.fr_mul2 = 1'b1;
        state_d = S_FSUM;
      end
      S_FSUM: begin
        cmd_o.frame = 1'b1;
        cmd_o.fr_sum = 1'b1;
        dc_d = 6'(DIV_LAST);
        state_d = S_FDIV;
      end
      S_FDIV: begin
        cmd_o.frame = 1'b1;
        cmd_o.fr_div = 1'b1;
        if (dc_q == '0) begin
          state_d = S_FWB;
        end else begin
          dc_d = dc_q - 6'd1;
        end
      end
      S_FWB: begin
        cmd_o.frame = 1'b1;
        cmd_o.fr_wb = 1'b1;
        if (!ax_q) begin
          ax_d = 1'b1;
          state_d = S_FMUL1;
        end else begin
          ax_d = 1'b0;
          if (p_q == P_LAST) begin
            state_d = S_DONE;
          end else begin
            p_d = p_q + H_W'(1);
            state_d = S_FCHK;
          end
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      p_q     <= '0;
      ax_q    <= 1'b0;
      dc_q    <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      p_q     <= p_d;
      ax_q    <= ax_d;
      dc_q    <= dc_d;
    end
  end

endmodule

// ===== design/lsc_dp.sv =====
module lsc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsc_pkg::in_item_t  in_data_i,
  input  logic               cfg_we_i,
  input  lsc_pkg::cfg_item_t cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output lsc_pkg::out_item_t out_data_o,
  input  lsc_pkg::cmd_t      cmd_i,
  output lsc_pkg::stat_t     stat_o
);
  import lsc_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  // configuration
  logic [10:0] cw_q, ch_q;
  logic [31:0] bg_q;
  logic [7:0]  rate_q;

  in_item_t it_q;

  logic [DIM_W-1:0]  dimw_q [SLOTS];
  logic [DIM_W-1:0]  dimh_q [SLOTS];
  logic [USR_W-1:0]  users_q [SLOTS];
  logic [PLC-1:0]    pvalid_q;
  logic [SLOT_W-1:0] pslot_q [PLC];
  logic signed [15:0] px_q [PLC];
  logic signed [15:0] py_q [PLC];
  logic signed [15:0] pvx_q [PLC];
  logic signed [15:0] pvy_q [PLC];
  logic signed [15:0] pax_q [PLC];
  logic signed [15:0] pay_q [PLC];
  logic signed [15:0] posx_q [PLC];
  logic signed [15:0] posy_q [PLC];
  logic [H_W-1:0]    lord_q [PLC];
  logic [H_W-1:0]    lord_d [PLC];
  logic [CNT_W-1:0]  lcnt_q;

  out_item_t pend_q, exec_res;
  out_item_t res_q;
  logic      ovalid_q;

  // motion arithmetic
  logic [31:0]             ff_q;
  logic [DEN_W-1:0]        den_q;
  logic signed [32:0]      vf_q;
  logic signed [33:0]      t1_q;
  logic signed [41:0]      t2_q;
  logic signed [48:0]      t3_q;
  logic                    neg_q;
  logic [MAG_W-1:0]        dq_q;
  logic [DEN_W-1:0]        rem_q;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag;
  logic [DEN_W:0]          trial;
  logic                    qbit;
  logic signed [15:0]      wb_val;

  logic [SLOT_W-1:0] si, sidx;
  logic [H_W-1:0]    hi, rd_p, fh;
  logic signed [15:0] cx, cy, st, sv, sa;
  logic [DIM_W-1:0]  dw, dh;
  logic [USR_W-1:0]  us;
  logic              size_bad, pix_bad, any_free;
  logic signed [16:0] dx, dy;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;

  assign si = it_q.sprite_slot;
  assign hi = it_q.placement_handle;
  assign cx = it_q.coord_x;
  assign cy = it_q.coord_y;

  // one read port per placement array: reorder uses the handle, frame its counter, query the layer list
  assign rd_p = cmd_i.reorder ? hi : (cmd_i.frame ? cmd_i.fr_p : lord_q[cmd_i.lidx]);
  assign sidx = cmd_i.exec ? si : pslot_q[rd_p];
  assign dw   = dimw_q[sidx];
  assign dh   = dimh_q[sidx];
  assign us   = users_q[sidx];

  assign size_bad = (cx < 16'sd1) || (cx > $signed(16'(SIDE))) ||
                    (cy < 16'sd1) || (cy > $signed(16'(SIDE)));
  assign pix_bad  = cx[15] || cy[15] || (cx >= $signed({9'd0, dw})) ||
                    (cy >= $signed({9'd0, dh}));

  always_comb begin
    fh = '0;
    for (int j = PLC - 1; j >= 0; j--) begin
      if (!pvalid_q[j]) begin
        fh = H_W'(j);
      end
    end
  end
  assign any_free = ~&pvalid_q;

  always_comb begin
    exec_res = '0;
    case (kind_e'(it_q.kind))
      K_SIZE: begin
        if (size_bad) exec_res.status = ST_FULL;
        else if (us != '0) exec_res.status = ST_INUSE;
      end
      K_LOAD: begin
        if (dw == '0) exec_res.status = ST_BAD;
        else if (pix_bad) exec_res.status = ST_FULL;
      end
      K_FREE: begin
        if (dw == '0) exec_res.status = ST_BAD;
        else if (us != '0) exec_res.status = ST_INUSE;
      end
      K_PLACE: begin
        if (dw == '0) exec_res.status = ST_BAD;
        else if (!any_free) exec_res.status = ST_FULL;
        else exec_res.new_handle = fh;
      end
      K_RAISE, K_LOWER, K_TOP, K_BOTTOM, K_REMOVE, K_MOTION: begin
        if (!pvalid_q[hi]) exec_res.status = ST_BAD;
      end
      K_READ: exec_res.color_out = bg_q;
      default: exec_res = '0;
    endcase
  end

  // layer list rewrite, every entry looks at its own neighbors
  always_comb begin
    logic [CNT_W-1:0] ii;
    logic [CNT_W-1:0] jj;
    ii = {1'b0, cmd_i.lidx};
    for (int j = 0; j < PLC; j++) begin
      jj = CNT_W'(j);
      lord_d[j] = lord_q[j];
      case (kind_e'(it_q.kind))
        K_RAISE: begin
          if (ii + CNT_W'(1) < lcnt_q) begin
            if (jj == ii) lord_d[j] = lord_q[(j + 1) % PLC];
            if (jj == ii + CNT_W'(1)) lord_d[j] = hi;
          end
        end
        K_LOWER: begin
          if (ii != '0) begin
            if (jj == ii) lord_d[j] = lord_q[(j + PLC - 1) % PLC];
            if (jj + CNT_W'(1) == ii) lord_d[j] = hi;
          end
        end
        K_TOP: begin
          if (jj >= ii && jj + CNT_W'(1) < lcnt_q) lord_d[j] = lord_q[(j + 1) % PLC];
          if (jj + CNT_W'(1) == lcnt_q) lord_d[j] = hi;
        end
        K_BOTTOM: begin
          if (jj <= ii && j > 0) lord_d[j] = lord_q[(j + PLC - 1) % PLC];
          if (j == 0) lord_d[j] = hi;
        end
        K_REMOVE: begin
          if (jj >= ii && jj + CNT_W'(1) < lcnt_q) lord_d[j] = lord_q[(j + 1) % PLC];
        end
        default: lord_d[j] = lord_q[j];
      endcase
    end
  end

  // query probe
  assign dx = {cx[15], cx} - {posx_q[rd_p][15], posx_q[rd_p]};
  assign dy = {cy[15], cy} - {posy_q[rd_p][15], posy_q[rd_p]};
  assign ram_raddr = {sidx, dy[SIDE_W-1:0], dx[SIDE_W-1:0]};
  assign ram_waddr = {si, cy[SIDE_W-1:0], cx[SIDE_W-1:0]};
  assign ram_we = cmd_i.exec && (it_q.kind == K_LOAD) && (dw != '0) && !pix_bad;

  lsc_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({it_q.pixel_opaque, it_q.pixel_color}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // motion: start, velocity, acceleration of the selected axis
  assign st = cmd_i.fr_axis ? py_q[rd_p] : px_q[rd_p];
  assign sv = cmd_i.fr_axis ? pvy_q[rd_p] : pvx_q[rd_p];
  assign sa = cmd_i.fr_axis ? pay_q[rd_p] : pax_q[rd_p];

  assign num = NUM_W'(t1_q) + NUM_W'($signed({t2_q, 1'b0})) + NUM_W'(t3_q);
  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign trial = {rem_q, dq_q[MAG_W-1]};
  assign qbit = trial >= {1'b0, den_q};

  always_comb begin
    if (rate_q == '0) begin
      wb_val = st;
    end else if (neg_q) begin
      wb_val = (dq_q > MAG_W'(32768)) ? -16'sd32768 : -$signed(dq_q[15:0]);
    end else begin
      wb_val = (dq_q > MAG_W'(32767)) ? 16'sd32767 : $signed(dq_q[15:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fr_init) begin
      ff_q  <= 32'(it_q.frame_number) * 32'(it_q.frame_number);
      den_q <= {16'(rate_q) * 16'(rate_q), 1'b0};
    end
    if (cmd_i.fr_mul1) begin
      vf_q <= sv * $signed({1'b0, it_q.frame_number});
      t1_q <= $signed({1'b0, den_q}) * st;
      t3_q <= sa * $signed({1'b0, ff_q});
    end
    if (cmd_i.fr_mul2) begin
      t2_q <= vf_q * $signed({1'b0, rate_q});
    end
    if (cmd_i.fr_sum) begin
      neg_q <= num[NUM_W-1];
      dq_q  <= mag[MAG_W-1:0];
      rem_q <= '0;
    end
    if (cmd_i.fr_div) begin
      rem_q <= qbit ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      dq_q  <= {dq_q[MAG_W-2:0], qbit};
    end
  end

  // payload arrays
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      it_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      pend_q <= exec_res;
      if (it_q.kind == K_PLACE && dw != '0 && any_free) begin
        pslot_q[fh] <= si;
        px_q[fh]    <= cx;
        py_q[fh]    <= cy;
        pvx_q[fh]   <= '0;
        pvy_q[fh]   <= '0;
        pax_q[fh]   <= '0;
        pay_q[fh]   <= '0;
        posx_q[fh]  <= cx;
        posy_q[fh]  <= cy;
      end
      if (it_q.kind == K_MOTION && pvalid_q[hi]) begin
        pvx_q[hi] <= it_q.vel_x;
        pvy_q[hi] <= it_q.vel_y;
        pax_q[hi] <= it_q.acc_x;
        pay_q[hi] <= it_q.acc_y;
      end
    end
    if (cmd_i.q_take) begin
      pend_q.color_out <= ram_rdata[31:0];
    end
    if (cmd_i.fr_wb) begin
      if (cmd_i.fr_axis) posy_q[rd_p] <= wb_val;
      else posx_q[rd_p] <= wb_val;
    end
    if (cmd_i.load_out) begin
      res_q <= pend_q;
    end
    if (cmd_i.reorder) begin
      lord_q <= lord_d;
    end else if (cmd_i.exec && it_q.kind == K_PLACE && dw != '0 && any_free) begin
      lord_q[lcnt_q[H_W-1:0]] <= fh;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q     <= 11'd640;
      ch_q     <= 11'd480;
      bg_q     <= '0;
      rate_q   <= 8'd30;
      pvalid_q <= '0;
      lcnt_q   <= '0;
      ovalid_q <= 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
        dimw_q[j]  <= '0;
        dimh_q[j]  <= '0;
        users_q[j] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_data_i.index))
          R_CANVAS_W: cw_q <= cfg_data_i.data[10:0];
          R_CANVAS_H: ch_q <= cfg_data_i.data[10:0];
          R_BG_COLOR: bg_q <= cfg_data_i.data;
          R_RATE:     rate_q <= cfg_data_i.data[7:0];
          default:    bg_q <= bg_q;
        endcase
      end
      if (cmd_i.load_out) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cmd_i.exec) begin
        case (kind_e'(it_q.kind))
          K_SIZE: begin
            if (!size_bad && us == '0) begin
              dimw_q[si] <= cx[DIM_W-1:0];
              dimh_q[si] <= cy[DIM_W-1:0];
            end
          end
          K_FREE: begin
            if (dw != '0 && us == '0) begin
              dimw_q[si] <= '0;
              dimh_q[si] <= '0;
            end
          end
          K_PLACE: begin
            if (dw != '0 && any_free) begin
              pvalid_q[fh] <= 1'b1;
              lcnt_q       <= lcnt_q + CNT_W'(1);
              users_q[si]  <= us + USR_W'(1);
            end
          end
          default: lcnt_q <= lcnt_q;
        endcase
      end
      if (cmd_i.reorder && it_q.kind == K_REMOVE) begin
        pvalid_q[hi] <= 1'b0;
        if (lcnt_q != '0) lcnt_q <= lcnt_q - CNT_W'(1);
        if (us != '0) users_q[sidx] <= us - USR_W'(1);
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = res_q;

  assign stat_o.kind      = it_q.kind;
  assign stat_o.h_ok      = pvalid_q[hi];
  assign stat_o.in_canvas = !cx[15] && !cy[15] && (cx[14:0] < {4'd0, cw_q}) &&
                            (cy[14:0] < {4'd0, ch_q});
  assign stat_o.find_hit  = lord_q[cmd_i.lidx] == hi;
  assign stat_o.q_inside  = !dx[16] && !dy[16] && (dx < $signed({10'd0, dw})) &&
                            (dy < $signed({10'd0, dh}));
  assign stat_o.q_opaque  = ram_rdata[PIX_W-1];
  assign stat_o.p_valid   = pvalid_q[cmd_i.fr_p];
  assign stat_o.out_free  = !ovalid_q || out_ready_i;
  assign stat_o.lcount    = lcnt_q;

endmodule

// ===== design/layered_sprite_compositor_core.sv =====
// one item at a time; a new item is taken only when the previous one has finished
// simple items go from accept through execute to the result register; reorder items add the layer search
// a pixel query probes layers top-down, with a store read for each layer that holds the point
// begin frame runs each placed axis through the shared bit-serial divider
// reset (async, active low) empties all slots and placements and loads the register defaults
// the sprite store is not cleared at reset; pixels read before they are loaded are undefined
module layered_sprite_compositor_core (
  input logic      clk_i,
  input logic      rst_ni,
  lsc_in_if.sink   in_i,
  lsc_out_if.source out_o,
  lsc_cfg_if.sink  cfg_i
);
  import lsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  lsc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lsc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_i.data),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_o.valid),
    .out_data_o (out_o.data),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

// ===== test/layered_sprite_compositor_core_tb.sv =====
module layered_sprite_compositor_core_tb;
  import lsc_pkg::*;

  localparam int           IDLE_LIMIT = 20000;
  localparam logic [3:0]   K_SPARE_LO = 4'd12;
  localparam int           PHASE_ITEMS = 285;

  // shadow of the compositor: sprite bitmaps, placements, layer stack
  class sprite_scoreboard;
    int unsigned cw, ch, rate;
    logic [31:0] bg;
    logic [31:0] pix_color [STORE_DEPTH];
    bit          pix_opq [STORE_DEPTH];
    bit          pix_set [STORE_DEPTH];
    int          dim_w [SLOTS];
    int          dim_h [SLOTS];
    int          users [SLOTS];
    bit          pv [PLC];
    int          pslot [PLC];
    int          sx [PLC], sy [PLC], vx [PLC], vy [PLC], ax [PLC], ay [PLC];
    int          posx [PLC], posy [PLC];
    int          order [PLC];
    int          lcount;
    out_item_t   awaited[$];
    int          errors;

    function new();
      cw = 640; ch = 480; bg = '0; rate = 30;
      lcount = 0; errors = 0;
      for (int i = 0; i < SLOTS; i++) begin
        dim_w[i] = 0; dim_h[i] = 0; users[i] = 0;
      end
      for (int i = 0; i < PLC; i++) begin
        pv[i] = 0; posx[i] = 0; posy[i] = 0; order[i] = 0;
      end
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] v);
      case (idx)
        R_CANVAS_W: cw = 32'(v[10:0]);
        R_CANVAS_H: ch = 32'(v[10:0]);
        R_BG_COLOR: bg = v;
        R_RATE:     rate = 32'(v[7:0]);
        default: ;
      endcase
    endfunction

    function int axis(int start, int v, int a, int f);
      longint den, num, q;
      if (rate == 0) return start;
      den = 2 * longint'(rate) * longint'(rate);
      num = den * start + 2 * longint'(v) * f * longint'(rate) + longint'(a) * f * f;
      q = num / den;
      if (q > 32767) return 32767;
      if (q < -32768) return -32768;
      return int'(q);
    endfunction

    function int layer_of(int h);
      for (int i = 0; i < lcount; i++)
        if (order[i] == h) return i;
      return 0;
    endfunction

    function void layer_drop(int i);
      for (; i + 1 < lcount; i++) order[i] = order[i + 1];
      if (lcount > 0) lcount--;
    endfunction

    function bit fully_loaded(int s);
      if (dim_w[s] == 0) return 0;
      for (int y = 0; y < dim_h[s]; y++)
        for (int x = 0; x < dim_w[s]; x++)
          if (!pix_set[(s * SIDE + y) * SIDE + x]) return 0;
      return 1;
    endfunction

    function bit next_gap(output int s, output int x, output int y);
      for (int k = 0; k < SLOTS; k++)
        if (dim_w[k] != 0)
          for (int yy = 0; yy < dim_h[k]; yy++)
            for (int xx = 0; xx < dim_w[k]; xx++)
              if (!pix_set[(k * SIDE + yy) * SIDE + xx]) begin
                s = k; x = xx; y = yy;
                return 1;
              end
      return 0;
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      int cx, cy, s, h, i, j, a, p, q, dx, dy, f;
      cx = int'(it.coord_x);
      cy = int'(it.coord_y);
      s = int'(it.sprite_slot);
      h = int'(it.placement_handle);
      r = '0;
      r.status = ST_OK;
      case (it.kind)
        K_SIZE: begin
          if (cx < 1 || cx > SIDE || cy < 1 || cy > SIDE) r.status = ST_FULL;
          else if (users[s] != 0) r.status = ST_INUSE;
          else begin
            dim_w[s] = cx; dim_h[s] = cy;
          end
        end
        K_LOAD: begin
          if (dim_w[s] == 0) r.status = ST_BAD;
          else if (cx < 0 || cy < 0 || cx >= dim_w[s] || cy >= dim_h[s]) r.status = ST_FULL;
          else begin
            a = (s * SIDE + cy) * SIDE + cx;
            pix_color[a] = it.pixel_color;
            pix_opq[a] = it.pixel_opaque;
            pix_set[a] = 1;
          end
        end
        K_FREE: begin
          if (dim_w[s] == 0) r.status = ST_BAD;
          else if (users[s] != 0) r.status = ST_INUSE;
          else begin
            dim_w[s] = 0; dim_h[s] = 0;
          end
        end
        K_PLACE: begin
          if (dim_w[s] == 0) r.status = ST_BAD;
          else begin
            for (i = 0; i < PLC; i++) if (!pv[i]) break;
            if (i >= PLC || lcount >= PLC) r.status = ST_FULL;
            else begin
              pv[i] = 1; pslot[i] = s;
              sx[i] = cx; sy[i] = cy;
              vx[i] = 0; vy[i] = 0; ax[i] = 0; ay[i] = 0;
              posx[i] = cx; posy[i] = cy;
              order[lcount] = i;
              lcount++;
              users[s]++;
              r.new_handle = 4'(i);
            end
          end
        end
        K_RAISE, K_LOWER, K_TOP, K_BOTTOM, K_REMOVE, K_MOTION: begin
          if (!pv[h]) r.status = ST_BAD;
          else if (it.kind == K_MOTION) begin
            vx[h] = int'(it.vel_x); vy[h] = int'(it.vel_y);
            ax[h] = int'(it.acc_x); ay[h] = int'(it.acc_y);
          end else begin
            i = layer_of(h);
            case (it.kind)
              K_RAISE: if (i + 1 < lcount) begin
                order[i] = order[i + 1]; order[i + 1] = h;
              end
              K_LOWER: if (i > 0) begin
                order[i] = order[i - 1]; order[i - 1] = h;
              end
              K_TOP: begin
                layer_drop(i);
                order[lcount % PLC] = h;
                lcount++;
              end
              K_BOTTOM: begin
                for (j = i; j > 0; j--) order[j] = order[j - 1];
                order[0] = h;
              end
              default: begin
                layer_drop(i);
                pv[h] = 0;
                if (users[pslot[h]] > 0) users[pslot[h]]--;
              end
            endcase
          end
        end
        K_FRAME: begin
          f = int'(it.frame_number);
          for (i = 0; i < PLC; i++)
            if (pv[i]) begin
              posx[i] = axis(sx[i], vx[i], ax[i], f);
              posy[i] = axis(sy[i], vy[i], ay[i], f);
            end
        end
        K_READ: begin
          r.color_out = bg;
          if (!(cx < 0 || cy < 0 || cx >= int'(cw) || cy >= int'(ch)))
            for (i = lcount; i > 0; i--) begin
              p = order[i - 1];
              q = pslot[p];
              dx = cx - posx[p];
              dy = cy - posy[p];
              if (dx < 0 || dy < 0 || dx >= dim_w[q] || dy >= dim_h[q]) continue;
              a = (q * SIDE + dy) * SIDE + dx;
              if (pix_opq[a]) begin
                r.color_out = pix_color[a];
                break;
              end
            end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.new_handle !== exp.new_handle) begin
        $display("%0t: new_handle expected %0d actual %0d", $time, exp.new_handle,
                 got.new_handle);
        errors++;
      end
      if (got.color_out !== exp.color_out) begin
        $display("%0t: color_out expected %h actual %h", $time, exp.color_out, got.color_out);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  lsc_in_if  in_bus();
  lsc_out_if out_bus();
  lsc_cfg_if cfg_bus();

  sprite_scoreboard sb;
  int send_pct;
  int recv_pct;
  int stall_left;
  int quiet_cycles;

  layered_sprite_compositor_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) sb.check_result(out_bus.data);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(in_item_t it);
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_bus.data  <= it;
    in_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    sb.note_item(it);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] v);
    cfg_bus.data.index <= idx;
    cfg_bus.data.data  <= v;
    cfg_bus.valid      <= 1'b1;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  // block holds one item at a time, so once the queue drains it is idle
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  function automatic in_item_t blank_item(kind_e k);
    in_item_t it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.kind = k;
    return it;
  endfunction

  function automatic int pick_handle();
    int cand[$];
    for (int i = 0; i < PLC; i++) if (sb.pv[i]) cand.push_back(i);
    if (cand.size() == 0 || $urandom_range(99) < 15) return $urandom_range(PLC - 1);
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  function automatic in_item_t gen_item();
    in_item_t it;
    int roll, s, x, y, h;
    int ready_slots[$];
    roll = $urandom_range(99);
    if (roll < 8) begin
      it = blank_item(K_SIZE);
      case ($urandom_range(19))
        0: begin it.coord_x = 16'($urandom); it.coord_y = 16'($urandom); end
        1: begin it.coord_x = 16'(SIDE); it.coord_y = 1; end
        2: begin it.coord_x = 1; it.coord_y = 16'(SIDE); end
        3: begin it.coord_x = 0; it.coord_y = 16'(SIDE + 1); end
        default: begin
          it.coord_x = 16'($urandom_range(1, 6)); it.coord_y = 16'($urandom_range(1, 6));
        end
      endcase
    end else if (roll < 33) begin
      it = blank_item(K_LOAD);
      if ($urandom_range(99) < 75 && sb.next_gap(s, x, y)) begin
        it.sprite_slot = 3'(s); it.coord_x = 16'(x); it.coord_y = 16'(y);
      end else if ($urandom_range(3) == 0) begin
        it.coord_x = 16'($urandom); it.coord_y = 16'($urandom);
      end else begin
        it.coord_x = 16'($urandom_range(7)); it.coord_y = 16'($urandom_range(7));
      end
      it.pixel_opaque = ($urandom_range(3) != 0);
    end else if (roll < 37) begin
      it = blank_item(K_FREE);
    end else if (roll < 48) begin
      it = blank_item(K_PLACE);
      for (int k = 0; k < SLOTS; k++)
        if (sb.fully_loaded(k)) ready_slots.push_back(k);
      if (ready_slots.size() == 0) begin
        it = blank_item(K_READ);
      end else begin
        it.sprite_slot = 3'(ready_slots[$urandom_range(ready_slots.size() - 1)]);
        if ($urandom_range(9) == 0) begin
          it.coord_x = 16'($urandom); it.coord_y = 16'($urandom);
        end else begin
          it.coord_x = 16'($signed($urandom_range(24)) - 4);
          it.coord_y = 16'($signed($urandom_range(24)) - 4);
        end
      end
    end else if (roll < 68) begin
      it = blank_item(kind_e'(4'(K_RAISE + $urandom_range(4))));
      it.placement_handle = 4'(pick_handle());
    end else if (roll < 75) begin
      it = blank_item(K_MOTION);
      it.placement_handle = 4'(pick_handle());
      if ($urandom_range(1) == 0) begin
        it.vel_x = 16'($signed($urandom_range(200)) - 100);
        it.vel_y = 16'($signed($urandom_range(200)) - 100);
        it.acc_x = 16'($signed($urandom_range(60)) - 30);
        it.acc_y = 16'($signed($urandom_range(60)) - 30);
      end
    end else if (roll < 80) begin
      it = blank_item(K_FRAME);
      if ($urandom_range(1) == 0) it.frame_number = 16'($urandom_range(60));
    end else if (roll < 98) begin
      it = blank_item(K_READ);
    end else begin
      it = blank_item(kind_e'(K_SPARE_LO));
      it.kind = 4'(K_SPARE_LO + $urandom_range(3));
    end
    if (it.kind == K_READ) begin
      h = pick_handle();
      case ($urandom_range(9))
        0: begin it.coord_x = 16'($urandom); it.coord_y = 16'($urandom); end
        1: begin it.coord_x = 16'(sb.cw); it.coord_y = 16'(sb.ch - 1); end
        2: begin it.coord_x = 16'(sb.cw - 1); it.coord_y = 16'(sb.ch); end
        3: begin
          it.coord_x = 16'($urandom_range(sb.cw - 1));
          it.coord_y = 16'($urandom_range(sb.ch - 1));
        end
        default: begin
          it.coord_x = 16'(sb.posx[h] + $signed($urandom_range(9)) - 2);
          it.coord_y = 16'(sb.posy[h] + $signed($urandom_range(9)) - 2);
        end
      endcase
    end
    return it;
  endfunction

  task automatic directed();
    in_item_t it;
    it = blank_item(K_SIZE); it.sprite_slot = 0;
    it.coord_x = 16'(SIDE); it.coord_y = 16'(SIDE);
    send_item(it);
    it = blank_item(K_LOAD); it.sprite_slot = 0;
    it.coord_x = 16'(SIDE - 1); it.coord_y = 16'(SIDE - 1);
    send_item(it);
    it.coord_x = 16'(SIDE); it.coord_y = 0;
    send_item(it);
    it = blank_item(K_FREE); it.sprite_slot = 0;
    send_item(it);
    it = blank_item(K_SIZE); it.sprite_slot = 1; it.coord_x = 0; it.coord_y = 0;
    send_item(it);
    it.coord_x = -16'sd1; it.coord_y = 16'sh8000;
    send_item(it);
    it.coord_x = 2; it.coord_y = 1;
    send_item(it);
    it = blank_item(K_LOAD); it.sprite_slot = 1; it.coord_x = 0; it.coord_y = 0;
    it.pixel_color = '1; it.pixel_opaque = 1;
    send_item(it);
    it.coord_x = 1; it.pixel_color = '0; it.pixel_opaque = 0;
    send_item(it);
    it = blank_item(K_PLACE); it.sprite_slot = 1; it.coord_x = 16'sh8000; it.coord_y = 16'sh7fff;
    send_item(it);
    it.coord_x = 0; it.coord_y = 0;
    send_item(it);
    it = blank_item(K_READ); it.coord_x = 0; it.coord_y = 0;
    send_item(it);
    it.coord_x = 1;
    send_item(it);
    it = blank_item(K_FREE); it.sprite_slot = 1;
    send_item(it);
    it = blank_item(K_SIZE); it.sprite_slot = 1; it.coord_x = 1; it.coord_y = 1;
    send_item(it);
    it = blank_item(K_RAISE); it.placement_handle = 1;
    send_item(it);
    it = blank_item(K_LOWER); it.placement_handle = 0;
    send_item(it);
    it = blank_item(K_TOP); it.placement_handle = 0;
    send_item(it);
    it = blank_item(K_BOTTOM); it.placement_handle = 0;
    send_item(it);
    it = blank_item(K_MOTION); it.placement_handle = 0;
    it.vel_x = 16'sh7fff; it.vel_y = 16'sh8000; it.acc_x = 16'sh8000; it.acc_y = 16'sh7fff;
    send_item(it);
    it = blank_item(K_FRAME); it.frame_number = 16'hffff;
    send_item(it);
    it = blank_item(K_READ); it.coord_x = -16'sd1; it.coord_y = 0;
    send_item(it);
    it = blank_item(kind_e'(K_SPARE_LO)); it.kind = 4'hf;
    send_item(it);
    it = blank_item(K_REMOVE); it.placement_handle = 4'(PLC - 1);
    send_item(it);
    it.placement_handle = 0;
    send_item(it);
    it = blank_item(K_PLACE); it.sprite_slot = 3'(SLOTS - 1);
    send_item(it);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    send_pct = 0;
    recv_pct = 0;
    stall_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(R_CANVAS_W, 1); write_reg(R_CANVAS_H, 1);
          write_reg(R_BG_COLOR, 32'hffff_ffff); write_reg(R_RATE, 0);
        end
        1: begin
          write_reg(R_CANVAS_W, 1024); write_reg(R_CANVAS_H, 1024);
          write_reg(R_BG_COLOR, 0); write_reg(R_RATE, 255);
        end
        default: begin
          write_reg(R_CANVAS_W, $urandom_range(1, 1024));
          write_reg(R_CANVAS_H, $urandom_range(1, 1024));
          write_reg(R_BG_COLOR, $urandom);
          write_reg(R_RATE, $urandom_range(255));
        end
      endcase
      case (ph % 3)
        0: begin send_pct = 24; recv_pct = 80; end
        1: begin send_pct = 80; recv_pct = 24; end
        default: begin send_pct = 0; recv_pct = 0; end
      endcase
      // long receiver hold-off while items keep coming
      if (ph == 2) stall_left = 400;
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(gen_item());
    end
    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
